>>> rtl/core/bcwg_pkg.sv
`default_nettype none

package bcwg_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMP,
        ST_STEP,
        ST_PHASE,
        ST_SAMPLE,
        ST_DONE
    } state_t;

    // output waveform codes
    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_SINE  = 2'd1;
    localparam logic [1:0] MODE_TRI   = 2'd2;
    localparam logic [1:0] MODE_SQUARE = 2'd3;

    // configuration register indexes
    localparam logic REG_PWM_PERIOD = 1'b0;
    localparam logic REG_PHASE_STEP = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int DUTY_W     = 8;
    localparam int SINE_W     = 16;
    localparam int STEP_W     = 16;

    // floor(p * 99 / 100) == (p * 519057) >> 19 for any 8-bit p
    localparam int MUL_B_W = 19;
    localparam logic [MUL_B_W-1:0] AMP_RECIP = 19'd519057;
    localparam int AMP_SHIFT = 19;

    localparam logic [7:0]  PWM_PERIOD_RST = 8'd255;
    localparam logic [15:0] PHASE_STEP_RST = 16'd1678;
    localparam int FREQ_RST = 20;

    localparam longint Q30 = 64'sd1073741824;

    // Q30 product, truncated towards zero
    function automatic longint qmul(input longint a, input longint b);
        longint prod;
        prod = a * b;
        if (prod < 0)
            return -((-prod) >>> 30);
        return prod >>> 30;
    endfunction

    // sin(pi/2 * t), t in Q30
    function automatic longint quarter_sin(input longint t);
        longint t2;
        longint p;
        t2 = qmul(t, t);
        p  = 64'sd172272;
        p  = qmul(p, t2) - 64'sd5026993;
        p  = qmul(p, t2) + 64'sd85569306;
        p  = qmul(p, t2) - 64'sd693598668;
        p  = qmul(p, t2) + 64'sd1686629713;
        return qmul(p, t);
    endfunction

    // offset sine table entry, Q0.16, evaluated at elaboration
    function automatic logic [15:0] sine_entry(input int k, input int addr_bits);
        int     qb;
        int     quarter;
        int     q;
        int     r;
        int     rr;
        longint t;
        longint s;
        longint v;
        longint e;
        qb      = addr_bits - 2;
        quarter = 1 << qb;
        q       = k >> qb;
        r       = k & (quarter - 1);
        rr      = ((q & 1) != 0) ? (quarter - r) : r;
        t       = longint'(rr) <<< (30 - qb);
        s       = quarter_sin(t);
        v       = (q >= 2) ? (Q30 - s) : (Q30 + s);
        if (v < 0)
            v = 0;
        e = v >>> 15;
        if (e > 65535)
            e = 65535;
        return e[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcwg_sine_rom.sv
`default_nettype none

module bcwg_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  wire logic                            clk,
    input  wire logic [ADDR_BITS-1:0]            addr,
    output logic      [bcwg_pkg::SINE_W-1:0]     data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [bcwg_pkg::SINE_W-1:0] rom_mem [DEPTH];
    logic [bcwg_pkg::SINE_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_fill
        assign rom_mem[k] = bcwg_pkg::sine_entry(k, ADDR_BITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_mem[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bcwg_mul.sv
`default_nettype none

module bcwg_mul #(
    parameter int A_W = 25,
    parameter int B_W = 19
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic      [A_W+B_W-1:0]   p
);

    logic [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/core/button_controlled_waveform_generator_core.sv
// An accepted input beat steps through AMP, STEP, PHASE, SAMPLE and DONE to out_valid,
//   one tick at a time. The single shared multiplier is used for the amplitude, the
//   phase increment and the sample scaling, plus one sine ROM read.
// A finished result sits in the output register while the next tick is accepted.
// Reset (rst_n low, asynchronous): phase 0, frequency 20, constant mode, unlocked,
//   registers back to pwm_period 255 and phase_step_per_unit 1678.
`default_nettype none

module button_controlled_waveform_generator_core #(
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10,
    parameter int FREQ_BITS      = 14
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              left_button,
    input  wire logic                              mid_button,
    input  wire logic                              right_button,
    input  wire logic                              up_button,
    input  wire logic                              down_button,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [bcwg_pkg::DUTY_W-1:0]       duty_value,
    output logic      [1:0]                        current_mode,
    output logic      [FREQ_BITS-1:0]              current_frequency,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [bcwg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int INC_W   = FREQ_BITS + bcwg_pkg::STEP_W;
    localparam int TRI_W   = PHASE_BITS + 1;
    localparam int MUL_A_W = (TRI_W > INC_W) ? TRI_W : INC_W;
    localparam int MUL_B_W = bcwg_pkg::MUL_B_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = ((PHASE_BITS > INC_W) ? PHASE_BITS : INC_W) + 1;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};

    bcwg_pkg::state_t state_reg, state_next;

    logic [7:0]               pwm_period_reg;
    logic [15:0]              phase_step_reg;
    logic [PHASE_BITS-1:0]    phase_reg, phase_next;
    logic [FREQ_BITS-1:0]     freq_reg, freq_next;
    logic [1:0]               mode_reg, mode_next;
    logic                     lock_reg, lock_next;
    logic [7:0]               amp_reg;

    logic                     out_valid_reg;
    logic [7:0]               duty_reg, duty_next;
    logic [1:0]               mode_out_reg;
    logic [FREQ_BITS-1:0]     freq_out_reg;

    logic                     accept;
    logic                     out_load;
    logic                     mul_en;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        prod;

    logic [SUM_W-1:0]         phase_sum;
    logic [TRI_W-1:0]         tri_twice;
    logic [TRI_W-1:0]         tri_full;
    logic [TRI_W-1:0]         tri_d;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [bcwg_pkg::SINE_W-1:0] rom_data;

    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == bcwg_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    // button handling for the beat being accepted
    always_comb
    begin
        mode_next = mode_reg;
        lock_next = lock_reg;
        freq_next = freq_reg;
        if (left_button)
            mode_next = bcwg_pkg::MODE_SINE;
        if (mid_button)
        begin
            lock_next = 1'b0;
            mode_next = bcwg_pkg::MODE_TRI;
        end
        if (right_button)
            mode_next = bcwg_pkg::MODE_SQUARE;
        if (up_button && !lock_next)
        begin
            lock_next = 1'b1;
            if (freq_next != FREQ_MAX)
                freq_next = freq_next + 1'b1;
        end
        if (down_button && (freq_next != '0) && !lock_next)
        begin
            lock_next = 1'b1;
            freq_next = freq_next - 1'b1;
        end
    end

    // phase update; reaching one period returns to zero
    always_comb
    begin
        phase_sum = SUM_W'(phase_reg) + SUM_W'(prod[INC_W-1:0]);
        if (phase_sum >= (SUM_W'(1) << PHASE_BITS))
            phase_next = '0;
        else
            phase_next = phase_sum[PHASE_BITS-1:0];
    end

    // four sine cycles per phase period
    if (PHASE_BITS - 2 >= SINE_ADDR_BITS)
    begin : g_addr_trunc
        assign rom_addr = phase_next[PHASE_BITS-3 -: SINE_ADDR_BITS];
    end
    else
    begin : g_addr_pad
        assign rom_addr = {phase_next[PHASE_BITS-3:0],
                           {(SINE_ADDR_BITS-PHASE_BITS+2){1'b0}}};
    end

    bcwg_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // |1 - 2x| in PHASE_BITS fraction bits
    always_comb
    begin
        tri_twice = {phase_reg, 1'b0};
        tri_full  = TRI_W'(1) << PHASE_BITS;
        if (tri_twice > tri_full)
            tri_d = tri_twice - tri_full;
        else
            tri_d = tri_full - tri_twice;
    end

    bcwg_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcwg_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bcwg_pkg::ST_AMP;
            end
            bcwg_pkg::ST_AMP:    state_next = bcwg_pkg::ST_STEP;
            bcwg_pkg::ST_STEP:   state_next = bcwg_pkg::ST_PHASE;
            bcwg_pkg::ST_PHASE:  state_next = bcwg_pkg::ST_SAMPLE;
            bcwg_pkg::ST_SAMPLE: state_next = bcwg_pkg::ST_DONE;
            bcwg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = bcwg_pkg::ST_IDLE;
            end
            default:             state_next = bcwg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: input ready and multiplier operand selection
    always_comb
    begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            bcwg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bcwg_pkg::ST_AMP:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(pwm_period_reg);
                mul_b  = bcwg_pkg::AMP_RECIP;
            end
            bcwg_pkg::ST_STEP:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(freq_reg);
                mul_b  = MUL_B_W'(phase_step_reg);
            end
            bcwg_pkg::ST_SAMPLE:
            begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'(amp_reg);
                if (mode_reg == bcwg_pkg::MODE_SINE)
                    mul_a = MUL_A_W'(rom_data);
                else
                    mul_a = MUL_A_W'(tri_d);
            end
            bcwg_pkg::ST_PHASE,
            bcwg_pkg::ST_DONE:
            begin
                mul_en = 1'b0;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            bcwg_pkg::MODE_SINE:   duty_next = prod[bcwg_pkg::SINE_W +: 8];
            bcwg_pkg::MODE_TRI:    duty_next = prod[PHASE_BITS +: 8];
            bcwg_pkg::MODE_SQUARE: duty_next = phase_reg[PHASE_BITS-1] ? amp_reg : 8'd0;
            default:               duty_next = amp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bcwg_pkg::ST_IDLE;
            pwm_period_reg <= bcwg_pkg::PWM_PERIOD_RST;
            phase_step_reg <= bcwg_pkg::PHASE_STEP_RST;
            phase_reg      <= '0;
            freq_reg       <= FREQ_BITS'(bcwg_pkg::FREQ_RST);
            mode_reg       <= bcwg_pkg::MODE_CONST;
            lock_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bcwg_pkg::REG_PWM_PERIOD: pwm_period_reg <= cfg_data[7:0];
                    bcwg_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    default:                  pwm_period_reg <= pwm_period_reg;
                endcase
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                lock_reg <= lock_next;
                freq_reg <= freq_next;
            end
            if (state_reg == bcwg_pkg::ST_PHASE)
                phase_reg <= phase_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bcwg_pkg::ST_STEP)
            amp_reg <= prod[bcwg_pkg::AMP_SHIFT +: 8];
        if (out_load)
        begin
            duty_reg     <= duty_next;
            mode_out_reg <= mode_reg;
            freq_out_reg <= freq_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign duty_value        = duty_reg;
    assign current_mode      = mode_out_reg;
    assign current_frequency = freq_out_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready
    ) else $error("input taken while a tick is in progress");

    a_freq_only_on_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(freq_reg)
    ) else $error("frequency changed without an input beat");

    a_mid_unlocks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && mid_button && !up_button && !down_button) |=> !lock_reg
    ) else $error("mid button did not clear the lock");

endmodule

`default_nettype wire

>>> bench/button_controlled_waveform_generator_core_tb.sv
`timescale 1ns / 100ps

localparam int      PHASE_W  = 24;
localparam int      FREQ_W   = 14;
localparam int      SINE_AW  = 10;
localparam longint  Q30_ONE  = 64'sd1073741824;
localparam longint  PHASE_FULL = 64'sd16777216;
localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

typedef struct packed {
    logic [7:0]        duty;
    logic [1:0]        mode;
    logic [FREQ_W-1:0] freq;
} tick_result_t;

class waveform_scoreboard;
    logic [7:0]         pwm_period;
    logic [15:0]        step_unit;
    logic [PHASE_W-1:0] phase;
    logic [FREQ_W-1:0]  frequency;
    logic [1:0]         mode;
    logic               step_lock;
    logic [15:0]        sine_tab [0:(1<<SINE_AW)-1];
    tick_result_t       expected_ticks [$];
    int                 errors;

    function new();
        pwm_period = bcwg_pkg::PWM_PERIOD_RST;
        step_unit  = bcwg_pkg::PHASE_STEP_RST;
        phase      = '0;
        frequency  = FREQ_W'(bcwg_pkg::FREQ_RST);
        mode       = bcwg_pkg::MODE_CONST;
        step_lock  = 1'b0;
        errors     = 0;
        build_sine_tab();
    endfunction

    function longint q30_mul(longint a, longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // sin(pi/2 * t), t in Q30, odd polynomial in t
    function longint quarter_wave(longint t);
        longint t2;
        longint acc;
        t2  = q30_mul(t, t);
        acc = 64'sd172272;
        acc = q30_mul(acc, t2) - 64'sd5026993;
        acc = q30_mul(acc, t2) + 64'sd85569306;
        acc = q30_mul(acc, t2) - 64'sd693598668;
        acc = q30_mul(acc, t2) + 64'sd1686629713;
        return q30_mul(acc, t);
    endfunction

    function void build_sine_tab();
        int     quarter;
        int     q;
        int     r;
        int     rr;
        longint t;
        longint s;
        longint v;
        longint e;
        quarter = (1 << SINE_AW) / 4;
        for (int k = 0; k < (1 << SINE_AW); k++)
        begin
            q  = k / quarter;
            r  = k % quarter;
            rr = (q % 2 == 1) ? (quarter - r) : r;
            t  = (longint'(rr) * Q30_ONE) / quarter;
            s  = quarter_wave(t);
            v  = (q >= 2) ? (Q30_ONE - s) : (Q30_ONE + s);
            if (v < 0)
                v = 0;
            e = v >>> 15;
            if (e > 65535)
                e = 65535;
            sine_tab[k] = e[15:0];
        end
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
        if (idx == bcwg_pkg::REG_PWM_PERIOD)
            pwm_period = data[7:0];
        else
            step_unit = data;
    endfunction

    function int pending();
        return expected_ticks.size();
    endfunction

    // one timer tick: buttons, then phase, then the duty value from the new phase
    function void advance_tick(logic l, logic m, logic r, logic u, logic d);
        logic [63:0]  amp;
        logic [63:0]  nxt;
        logic [63:0]  twice;
        logic [63:0]  fold;
        logic [63:0]  duty;
        logic [63:0]  wide_phase;
        logic [63:0]  wide_freq;
        logic [63:0]  wide_step;
        logic [63:0]  rom_val;
        tick_result_t res;
        amp = 64'(pwm_period);
        amp = (amp * 99) / 100;
        if (l)
            mode = bcwg_pkg::MODE_SINE;
        if (m)
        begin
            step_lock = 1'b0;
            mode      = bcwg_pkg::MODE_TRI;
        end
        if (r)
            mode = bcwg_pkg::MODE_SQUARE;
        if (u && !step_lock)
        begin
            step_lock = 1'b1;
            if (frequency != FREQ_MAX)
                frequency = frequency + 1'b1;
        end
        if (d && frequency != 0 && !step_lock)
        begin
            step_lock = 1'b1;
            frequency = frequency - 1'b1;
        end
        wide_phase = 64'(phase);
        wide_freq  = 64'(frequency);
        wide_step  = 64'(step_unit);
        nxt = wide_phase + wide_freq * wide_step;
        // no remainder kept on reaching a full period
        phase = (nxt >= PHASE_FULL) ? '0 : nxt[PHASE_W-1:0];
        wide_phase = 64'(phase);
        case (mode)
            bcwg_pkg::MODE_SINE:
            begin
                rom_val = 64'(sine_tab[phase[PHASE_W-3 -: SINE_AW]]);
                duty = (rom_val * amp) >> 16;
            end
            bcwg_pkg::MODE_TRI:
            begin
                twice = wide_phase << 1;
                fold  = (twice > PHASE_FULL) ? (twice - PHASE_FULL) : (PHASE_FULL - twice);
                duty  = (fold * amp) >> PHASE_W;
            end
            bcwg_pkg::MODE_SQUARE:
                duty = phase[PHASE_W-1] ? amp : 64'd0;
            default:
                duty = amp;
        endcase
        res.duty = duty[7:0];
        res.mode = mode;
        res.freq = frequency;
        expected_ticks.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] expv, logic [15:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expv, actv);
            errors++;
        end
    endfunction

    function void check_tick(logic [7:0] duty, logic [1:0] md, logic [FREQ_W-1:0] freq);
        tick_result_t exp_r;
        if (expected_ticks.size() == 0)
        begin
            $display("%0t: unexpected beat: expected none, got duty %0d mode %0d freq %0d",
                     $time, duty, md, freq);
            errors++;
            return;
        end
        exp_r = expected_ticks.pop_front();
        compare_field("duty_value", 16'(exp_r.duty), 16'(duty));
        compare_field("current_mode", 16'(exp_r.mode), 16'(md));
        compare_field("current_frequency", 16'(exp_r.freq), 16'(freq));
    endfunction
endclass

module button_controlled_waveform_generator_core_tb;

    localparam logic [4:0] BTN_NONE  = 5'b00000;
    localparam logic [4:0] BTN_LEFT  = 5'b10000;
    localparam logic [4:0] BTN_MID   = 5'b01000;
    localparam logic [4:0] BTN_RIGHT = 5'b00100;
    localparam logic [4:0] BTN_UP    = 5'b00010;
    localparam logic [4:0] BTN_DOWN  = 5'b00001;
    localparam logic [4:0] BTN_MODES = BTN_LEFT | BTN_MID | BTN_RIGHT;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 500;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 150;
    localparam int RAMP_TICKS     = 40;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          left_button;
    logic                          mid_button;
    logic                          right_button;
    logic                          up_button;
    logic                          down_button;
    logic                          out_valid;
    logic                          out_ready;
    logic [bcwg_pkg::DUTY_W-1:0]   duty_value;
    logic [1:0]                    current_mode;
    logic [FREQ_W-1:0]             current_frequency;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [bcwg_pkg::CFG_DATA_W-1:0] cfg_data;

    waveform_scoreboard sb;
    int  send_gap_max;
    int  recv_gap_max;
    int  results_seen;
    int  quiet_cycles;
    bit  hold_done;
    logic [4:0] directed_btns [0:16];

    button_controlled_waveform_generator_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_button       (left_button),
        .mid_button        (mid_button),
        .right_button      (right_button),
        .up_button         (up_button),
        .down_button       (down_button),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .duty_value        (duty_value),
        .current_mode      (current_mode),
        .current_frequency (current_frequency),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat monitors; values seen here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.advance_tick(left_button, mid_button, right_button, up_button, down_button);
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_tick(duty_value, current_mode, current_frequency);
            results_seen++;
        end
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d ticks outstanding", $time, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, recv_gap_max);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_tick(input logic [4:0] btn);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {left_button, mid_button, right_button, up_button, down_button} <= btn;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic config_phase(input int sel);
        logic [7:0]  pwm;
        logic [7:0]  junk;
        logic [15:0] stp;
        junk = 8'($urandom_range(0, 255));
        case (sel % 6)
            0: pwm = 8'd0;
            1: pwm = 8'd1;
            2: pwm = 8'd100;
            3: pwm = 8'd101;
            4: pwm = 8'd255;
            default: pwm = 8'($urandom_range(0, 255));
        endcase
        case (sel % 5)
            0: stp = 16'd0;
            1: stp = 16'hFFFF;
            2: stp = 16'd1;
            3: stp = 16'($urandom_range(1, 4000));
            default: stp = 16'($urandom_range(0, 65535));
        endcase
        // upper byte of the period word is ignored by the block
        write_cfg(bcwg_pkg::REG_PWM_PERIOD, {junk, pwm});
        write_cfg(bcwg_pkg::REG_PHASE_STEP, stp);
    endtask

    function automatic logic [4:0] random_buttons();
        int kind;
        logic [4:0] btn;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
            btn = 5'($urandom_range(0, 31));
        else if (kind <= 6)
        begin
            btn = BTN_MID | ($urandom_range(0, 1) ? BTN_UP : BTN_DOWN);
            btn = btn | (5'($urandom_range(0, 31)) & (BTN_LEFT | BTN_RIGHT));
        end
        else if (kind == 7)
            btn = $urandom_range(0, 1) ? BTN_UP : BTN_DOWN;
        else
            btn = 5'($urandom_range(0, 31)) & BTN_MODES;
        return btn;
    endfunction

    initial
    begin
        int diff;
        int n;
        sb = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        left_button  <= 1'b0;
        mid_button   <= 1'b0;
        right_button <= 1'b0;
        up_button    <= 1'b0;
        down_button  <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= bcwg_pkg::REG_PWM_PERIOD;
        cfg_data     <= '0;
        quiet_cycles <= 0;
        results_seen  = 0;
        hold_done     = 1'b0;
        send_gap_max  = 10;
        recv_gap_max  = 10;
        directed_btns = '{BTN_NONE, BTN_LEFT, BTN_MID, BTN_RIGHT,
                          BTN_LEFT | BTN_MID, BTN_MID | BTN_RIGHT, BTN_LEFT | BTN_RIGHT,
                          BTN_MODES, BTN_UP, BTN_UP, BTN_DOWN, BTN_MID | BTN_DOWN,
                          BTN_MID | BTN_UP | BTN_DOWN, BTN_UP | BTN_DOWN, BTN_MID | BTN_UP,
                          5'b11111, BTN_NONE};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: mode priority, lock behaviour, up and down together
        foreach (directed_btns[i])
            send_tick(directed_btns[i]);
        drain();

        // run the phase to a full period so it restarts from zero
        write_cfg(bcwg_pkg::REG_PHASE_STEP, 16'hFFFF);
        while (sb.phase != 0)
        begin
            send_tick(BTN_NONE);
            drain();
        end
        // freeze the phase, set frequency 32, then 16 ticks land exactly on one period
        write_cfg(bcwg_pkg::REG_PHASE_STEP, 16'd0);
        diff = 32 - int'(sb.frequency);
        for (int i = 0; i < (diff < 0 ? -diff : diff); i++)
            send_tick(BTN_MID | (diff > 0 ? BTN_UP : BTN_DOWN));
        drain();
        write_cfg(bcwg_pkg::REG_PHASE_STEP, 16'd32768);
        for (int i = 0; i < 16; i++)
            send_tick(5'($urandom_range(0, 31)) & (BTN_LEFT | BTN_RIGHT));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            config_phase(p);
            for (int i = 0; i < PHASE_TICKS; i++)
                send_tick(random_buttons());
            drain();
        end

        // frequency down to zero and beyond; down at zero leaves the lock clear
        send_gap_max = 10;
        recv_gap_max = 10;
        config_phase(5);
        n = int'(sb.frequency) + 3;
        for (int i = 0; i < n; i++)
            send_tick(BTN_MID | BTN_DOWN | (5'($urandom_range(0, 31)) & BTN_RIGHT));
        send_tick(BTN_DOWN);
        send_tick(BTN_DOWN);
        send_tick(BTN_UP);
        send_tick(BTN_UP);
        drain();

        // short back-to-back ramp upwards
        send_gap_max = 0;
        recv_gap_max = 0;
        write_cfg(bcwg_pkg::REG_PHASE_STEP, 16'($urandom_range(0, 1023)));
        for (int i = 0; i < RAMP_TICKS; i++)
            send_tick(BTN_MID | BTN_UP | (5'($urandom_range(0, 31)) & (BTN_LEFT | BTN_RIGHT)));
        send_tick(BTN_UP);
        send_tick(BTN_LEFT | BTN_UP);
        drain();

        send_gap_max = 10;
        recv_gap_max = 10;
        config_phase(4);
        for (int i = 0; i < PHASE_TICKS; i++)
            send_tick(random_buttons());
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bcwg_pkg.sv
rtl/core/bcwg_sine_rom.sv
rtl/core/bcwg_mul.sv
rtl/core/button_controlled_waveform_generator_core.sv
bench/button_controlled_waveform_generator_core_tb.sv
